// ===== rtl/bmg_pkg.sv =====
// shared types, constants and latencies of the gaussian pair generator
`timescale 1ns / 1ps
package bmg_pkg;

  // field widths
  localparam int UNIFORM_BITS  = 24;
  localparam int OUT_FRAC_BITS = 20;
  localparam int SAMPLE_W      = 24;

  // internal fixed point format, unsigned Q56
  localparam int FQ = 56;
  localparam logic [63:0] ONE_Q   = 64'(1) << FQ;
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
  localparam logic [64:0] TWO_64  = 65'(1) << 64;

  // radius path
  localparam int V_W        = UNIFORM_BITS + 1;
  localparam int EXP_W      = $clog2(V_W);
  localparam int LOG_M_W    = FQ + 2;
  localparam int LOG_STEPS  = FQ;
  localparam int SQRT_STEPS = FQ + 3;
  localparam int SQ_R_W     = SQRT_STEPS;
  localparam int SQ_REM_W   = 2 * SQ_R_W + 2;
  localparam int SQ_POS_W   = $clog2(SQRT_STEPS);

  // angle path
  localparam int TAYLOR_TERMS = 30;
  localparam int SER_DIV_W    = $clog2(2 * TAYLOR_TERMS * (2 * TAYLOR_TERMS + 1) + 1);
  localparam int TRIG_W       = FQ + 1;

  // output rounding
  localparam int OUT_SHIFT = 2 * FQ - OUT_FRAC_BITS;
  localparam int MAG_W     = 128 - OUT_SHIFT;
  localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'((64'(1) << (SAMPLE_W - 1)) - 64'(1));
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(64'(1) << (SAMPLE_W - 1));

  // cell and path latencies in cycles
  localparam int MUL_LAT      = 2;
  localparam int LOG_CELL_LAT = MUL_LAT + 1;
  localparam int SER_CELL_LAT = 2 * MUL_LAT + 2;
  localparam int E_DLY        = LOG_STEPS * LOG_CELL_LAT;
  localparam int RAD_LAT      = 2 + E_DLY + 1 + MUL_LAT + 1 + SQRT_STEPS;
  localparam int ANG_LAT      = 2 * MUL_LAT + TAYLOR_TERMS * SER_CELL_LAT + 1;
  localparam int TRIG_ALIGN   = RAD_LAT - ANG_LAT;
  localparam int PIPE_LAT     = RAD_LAT + MUL_LAT + 1;
  localparam int SIDE_DLY     = PIPE_LAT - 1;

  // quadrant of the angle, from its top two bits
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quadrant_t;

  typedef struct packed {
    logic [UNIFORM_BITS-1:0] uniform_radius;
    logic [UNIFORM_BITS-1:0] uniform_angle;
    logic                    keep_second;
  } uniform_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_sin;
    logic signed [SAMPLE_W-1:0] sample_cos;
    logic                       cos_valid;
  } gauss_pair_t;

  // per item information carried beside the datapath
  typedef struct packed {
    quadrant_t quad;
    logic      keep;
  } side_t;

endpackage

// ===== rtl/box_muller_gaussian.sv =====
// Box-Muller gaussian pair generator, density proportional to exp(-x^2).
// Input channel uniform/uniform_valid/uniform_stall carries one transaction
// of two uniform fractions and a keep flag; output channel
// sample/sample_valid/sample_stall returns one transaction of two signed
// samples (sine and cosine branch) with OUT_FRAC_BITS fraction bits.
// Throughput: one transaction per cycle unless the receiver stalls a
// result; every arithmetic cell is pipelined. The radius path sets the
// latency (56 log cells, 59 root cells, plus the log scaling and output
// multiply stages).
// The angle path (two chains of 30 taylor cells) runs in parallel and is
// delayed to meet the radius.
// When the receiver stalls a finished result, the whole pipeline holds and
// a one-entry skid register still takes one more input transaction; the
// input stalls only while that register is full.
// Reset (synchronous, active high) empties the pipeline and the skid
// register; the datapath registers are not reset.
`timescale 1ns / 1ps
module box_muller_gaussian import bmg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  uniform_pair_t uniform,
  input  logic          uniform_valid,
  output logic          uniform_stall,
  output gauss_pair_t   sample,
  output logic          sample_valid,
  input  logic          sample_stall
);

  // handshake and skid register
  logic          adv;
  logic          hold_valid;
  uniform_pair_t hold;
  logic          entry_valid;
  uniform_pair_t entry;
  logic          vld [PIPE_LAT];
  side_t         side_dly [SIDE_DLY];

  // radius path
  logic [V_W-1:0]      v_r;
  logic [EXP_W-1:0]    e_next;
  logic [EXP_W-1:0]    e_r;
  logic [LOG_M_W-1:0]  log_m [LOG_STEPS+1];
  logic [FQ-1:0]       log_frac [LOG_STEPS+1];
  logic [EXP_W-1:0]    e_dly [E_DLY];
  logic [63:0]         nlog2;
  logic [127:0]        pln;
  logic [SQ_REM_W-1:0] sq_rem [SQRT_STEPS+1];
  logic [SQ_R_W-1:0]   sq_r [SQRT_STEPS+1];

  // angle path
  logic [127:0]       pang;
  logic [127:0]       px2;
  logic [63:0]        x_d [MUL_LAT];
  logic [63:0]        sin_term [TAYLOR_TERMS+1];
  logic [63:0]        sin_x2 [TAYLOR_TERMS+1];
  logic signed [63:0] sin_sum [TAYLOR_TERMS+1];
  logic [63:0]        cos_term [TAYLOR_TERMS+1];
  logic [63:0]        cos_x2 [TAYLOR_TERMS+1];
  logic signed [63:0] cos_sum [TAYLOR_TERMS+1];
  logic [TRIG_W-1:0]  s_cl;
  logic [TRIG_W-1:0]  c_cl;
  logic [TRIG_W-1:0]  s_dly [TRIG_ALIGN];
  logic [TRIG_W-1:0]  c_dly [TRIG_ALIGN];

  // output stage
  side_t             side_sel;
  side_t             side_out;
  logic              quad_even;
  logic [TRIG_W-1:0] trig_for_sin;
  logic [TRIG_W-1:0] trig_for_cos;
  logic [127:0]      p_sin;
  logic [127:0]      p_cos;
  logic              neg_sin;
  logic              neg_cos;
  gauss_pair_t       sample_r;

  // round to nearest, ties away from zero, then sign and saturate
  function automatic logic [SAMPLE_W-1:0] round_sat(input logic [127:0] p, input logic neg);
    logic [127:0]     acc;
    logic [MAG_W-1:0] mag;
    acc = p + (128'(1) << (OUT_SHIFT - 1));
    mag = acc[127:OUT_SHIFT];
    if (neg) begin
      if (mag > MAG_NEG_MAX) mag = MAG_NEG_MAX;
      return SAMPLE_W'(MAG_W'(0) - mag);
    end
    if (mag > MAG_POS_MAX) mag = MAG_POS_MAX;
    return SAMPLE_W'(mag);
  endfunction

  // pipeline advances unless a finished result is stalled
  assign adv           = !(sample_valid && sample_stall);
  assign uniform_stall = hold_valid;
  assign entry_valid   = hold_valid || uniform_valid;
  assign entry         = hold_valid ? hold : uniform;

  // skid register catches a transaction while the pipeline holds
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (adv) begin
      hold_valid <= 1'b0;
    end else if (uniform_valid && !hold_valid) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && uniform_valid && !hold_valid) begin
      hold <= uniform;
    end
  end

  // valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= entry_valid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // quadrant and keep flag travel beside the datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly[0] <= '{quad: quadrant_t'(entry.uniform_angle[UNIFORM_BITS-1 -: 2]),
                       keep: entry.keep_second};
      for (int i = 1; i < SIDE_DLY; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  // ---------------- radius ----------------

  // v = 1 - u1 scaled, then exponent and mantissa
  always_comb begin
    e_next = '0;
    for (int i = 0; i < V_W; i++) begin
      if (v_r[i]) e_next = EXP_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r      <= V_W'(V_W'(1) << UNIFORM_BITS) - V_W'(entry.uniform_radius);
      e_r      <= e_next;
      log_m[0] <= LOG_M_W'(v_r) << (FQ - int'(e_next));
    end
  end

  assign log_frac[0] = '0;

  // chain of log2 bit cells
  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    bmg_log_cell u_cell (
      .clk      (clk),
      .en       (adv),
      .m_in     (log_m[k]),
      .frac_in  (log_frac[k]),
      .m_out    (log_m[k+1]),
      .frac_out (log_frac[k+1])
    );
  end

  // exponent waits for the fraction
  always_ff @(posedge clk) begin
    if (adv) begin
      e_dly[0] <= e_r;
      for (int i = 1; i < E_DLY; i++) begin
        e_dly[i] <= e_dly[i-1];
      end
    end
  end

  // -log2(1 - u1), then scaled by ln 2
  always_ff @(posedge clk) begin
    if (adv) begin
      nlog2 <= (64'(UNIFORM_BITS - int'(e_dly[E_DLY-1])) << FQ) - 64'(log_frac[LOG_STEPS]);
    end
  end

  bmg_mul u_ln2 (
    .clk (clk),
    .en  (adv),
    .a   (nlog2),
    .b   (LN2_Q64),
    .p   (pln)
  );

  // largest r with trunc(r*r) <= L is the integer root of (L + 1) * 2^56 - 1
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0] <= ((SQ_REM_W'(pln[127:64]) + SQ_REM_W'(1)) << FQ) - SQ_REM_W'(1);
    end
  end

  assign sq_r[0] = '0;

  // chain of root digit cells, top digit first
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    bmg_sqrt_cell u_cell (
      .clk     (clk),
      .en      (adv),
      .bit_pos (SQ_POS_W'(SQRT_STEPS - 1 - k)),
      .rem_in  (sq_rem[k]),
      .r_in    (sq_r[k]),
      .rem_out (sq_rem[k+1]),
      .r_out   (sq_r[k+1])
    );
  end

  // ---------------- angle ----------------

  // x = 2 pi rem in Q56
  bmg_mul u_ang (
    .clk (clk),
    .en  (adv),
    .a   (64'(entry.uniform_angle[UNIFORM_BITS-3:0])),
    .b   (PI_Q60),
    .p   (pang)
  );

  bmg_mul u_x2 (
    .clk (clk),
    .en  (adv),
    .a   (pang[UNIFORM_BITS+3 +: 64]),
    .b   (pang[UNIFORM_BITS+3 +: 64]),
    .p   (px2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      x_d[0] <= pang[UNIFORM_BITS+3 +: 64];
      for (int i = 1; i < MUL_LAT; i++) begin
        x_d[i] <= x_d[i-1];
      end
    end
  end

  assign sin_term[0] = x_d[MUL_LAT-1];
  assign sin_x2[0]   = px2[FQ +: 64];
  assign sin_sum[0]  = $signed(x_d[MUL_LAT-1]);
  assign cos_term[0] = ONE_Q;
  assign cos_x2[0]   = px2[FQ +: 64];
  assign cos_sum[0]  = $signed(ONE_Q);

  // two chains of taylor cells, signs alternate starting with a subtraction
  for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_ser
    localparam int NS = 2 + 2 * k;
    localparam int NC = 1 + 2 * k;
    localparam logic [SER_DIV_W-1:0] DIV_S = SER_DIV_W'(NS * (NS + 1));
    localparam logic [SER_DIV_W-1:0] DIV_C = SER_DIV_W'(NC * (NC + 1));
    localparam logic [64:0] RCP_S = TWO_64 / 65'(DIV_S);
    localparam logic [64:0] RCP_C = TWO_64 / 65'(DIV_C);

    bmg_series_cell u_sin (
      .clk      (clk),
      .en       (adv),
      .recip    (RCP_S[63:0]),
      .div      (DIV_S),
      .add_term (1'(k % 2)),
      .term_in  (sin_term[k]),
      .x2_in    (sin_x2[k]),
      .sum_in   (sin_sum[k]),
      .term_out (sin_term[k+1]),
      .x2_out   (sin_x2[k+1]),
      .sum_out  (sin_sum[k+1])
    );

    bmg_series_cell u_cos (
      .clk      (clk),
      .en       (adv),
      .recip    (RCP_C[63:0]),
      .div      (DIV_C),
      .add_term (1'(k % 2)),
      .term_in  (cos_term[k]),
      .x2_in    (cos_x2[k]),
      .sum_in   (cos_sum[k]),
      .term_out (cos_term[k+1]),
      .x2_out   (cos_x2[k+1]),
      .sum_out  (cos_sum[k+1])
    );
  end

  // clamp magnitudes to [0, 1] and wait for the radius
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sin_sum[TAYLOR_TERMS] < 0) s_cl <= '0;
      else if (sin_sum[TAYLOR_TERMS] > $signed(ONE_Q)) s_cl <= TRIG_W'(ONE_Q);
      else s_cl <= TRIG_W'(sin_sum[TAYLOR_TERMS]);
      if (cos_sum[TAYLOR_TERMS] < 0) c_cl <= '0;
      else if (cos_sum[TAYLOR_TERMS] > $signed(ONE_Q)) c_cl <= TRIG_W'(ONE_Q);
      else c_cl <= TRIG_W'(cos_sum[TAYLOR_TERMS]);
      s_dly[0] <= s_cl;
      c_dly[0] <= c_cl;
      for (int i = 1; i < TRIG_ALIGN; i++) begin
        s_dly[i] <= s_dly[i-1];
        c_dly[i] <= c_dly[i-1];
      end
    end
  end

  // ---------------- output ----------------

  // quadrant picks which magnitude feeds each sample
  assign side_sel     = side_dly[RAD_LAT-1];
  assign quad_even    = (side_sel.quad == QUAD_I) || (side_sel.quad == QUAD_III);
  assign trig_for_sin = quad_even ? s_dly[TRIG_ALIGN-1] : c_dly[TRIG_ALIGN-1];
  assign trig_for_cos = quad_even ? c_dly[TRIG_ALIGN-1] : s_dly[TRIG_ALIGN-1];

  bmg_mul u_out_sin (
    .clk (clk),
    .en  (adv),
    .a   (64'(sq_r[SQRT_STEPS])),
    .b   (64'(trig_for_sin)),
    .p   (p_sin)
  );

  bmg_mul u_out_cos (
    .clk (clk),
    .en  (adv),
    .a   (64'(sq_r[SQRT_STEPS])),
    .b   (64'(trig_for_cos)),
    .p   (p_cos)
  );

  // sign of each sample by quadrant
  assign side_out = side_dly[SIDE_DLY-1];
  assign neg_sin  = (side_out.quad == QUAD_III) || (side_out.quad == QUAD_IV);
  assign neg_cos  = (side_out.quad == QUAD_II) || (side_out.quad == QUAD_III);

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      sample_r.sample_sin <= round_sat(p_sin, neg_sin);
      sample_r.sample_cos <= side_out.keep ? round_sat(p_cos, neg_cos) : '0;
      sample_r.cos_valid  <= side_out.keep;
    end
  end

  assign sample       = sample_r;
  assign sample_valid = vld[PIPE_LAT-1];

  // a transaction offered while the pipeline holds lands in the skid register
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    uniform_valid && !uniform_stall && !adv |=> hold_valid)
    else $error("skid register missed a transaction");

  // the skid register drains as soon as the pipeline moves
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    hold_valid && adv |=> !hold_valid)
    else $error("skid register did not drain");

  // a dropped cosine sample reads as zero
  a_cos_zero: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample.cos_valid |-> sample.sample_cos == '0)
    else $error("cosine sample not cleared");

  // a held result stays valid until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample_r))
    else $error("output register changed while stalled");

endmodule

// ===== rtl/bmg_mul.sv =====
// pipelined 64 x 64 multiplier built from four 32 x 32 partial products
`timescale 1ns / 1ps
module bmg_mul (
  input  logic         clk,
  input  logic         en,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0] pp_ll;
  logic [63:0] pp_lh;
  logic [63:0] pp_hl;
  logic [63:0] pp_hh;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[31:0] * b[31:0];
      pp_lh <= a[31:0] * b[63:32];
      pp_hl <= a[63:32] * b[31:0];
      pp_hh <= a[63:32] * b[63:32];
    end
  end

  // sum of partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p <= {pp_hh, 64'd0} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0} + {64'd0, pp_ll};
    end
  end

endmodule

// ===== rtl/bmg_log_cell.sv =====
// one bit of the base two logarithm: square the mantissa and renormalize
`timescale 1ns / 1ps
module bmg_log_cell import bmg_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [LOG_M_W-1:0] m_in,
  input  logic [FQ-1:0]      frac_in,
  output logic [LOG_M_W-1:0] m_out,
  output logic [FQ-1:0]      frac_out
);

  logic [127:0]       p;
  logic [LOG_M_W-1:0] sq;
  logic               ge_two;
  logic [FQ-1:0]      frac_d [MUL_LAT];

  bmg_mul u_sq (
    .clk (clk),
    .en  (en),
    .a   (64'(m_in)),
    .b   (64'(m_in)),
    .p   (p)
  );

  // truncated square, at least two means this bit is set
  assign sq     = p[FQ +: LOG_M_W];
  assign ge_two = sq[LOG_M_W-1];

  // fraction travels beside the multiplier
  always_ff @(posedge clk) begin
    if (en) begin
      frac_d[0] <= frac_in;
      for (int i = 1; i < MUL_LAT; i++) begin
        frac_d[i] <= frac_d[i-1];
      end
    end
  end

  // renormalize and shift the new bit in below the earlier ones
  always_ff @(posedge clk) begin
    if (en) begin
      m_out    <= ge_two ? (sq >> 1) : sq;
      frac_out <= {frac_d[MUL_LAT-1][FQ-2:0], ge_two};
    end
  end

endmodule

// ===== rtl/bmg_sqrt_cell.sv =====
// one digit of the restoring square root
`timescale 1ns / 1ps
module bmg_sqrt_cell import bmg_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_POS_W-1:0] bit_pos,
  input  logic [SQ_REM_W-1:0] rem_in,
  input  logic [SQ_R_W-1:0]   r_in,
  output logic [SQ_REM_W-1:0] rem_out,
  output logic [SQ_R_W-1:0]   r_out
);

  logic [SQ_REM_W-1:0] trial;
  logic                take;

  // (r + 2^i)^2 - r^2 = r * 2^(i+1) + 2^(2i)
  always_comb begin
    trial = (SQ_REM_W'(r_in) << ((SQ_POS_W + 1)'(bit_pos) + (SQ_POS_W + 1)'(1)))
          + (SQ_REM_W'(1) << {bit_pos, 1'b0});
    take  = (rem_in >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? (rem_in - trial) : rem_in;
      r_out   <= take ? (r_in | (SQ_R_W'(1) << bit_pos)) : r_in;
    end
  end

endmodule

// ===== rtl/bmg_series_cell.sv =====
// one taylor term: next term = trunc(term * x2) / (n (n + 1)), then accumulate
`timescale 1ns / 1ps
module bmg_series_cell import bmg_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [63:0]          recip,
  input  logic [SER_DIV_W-1:0] div,
  input  logic                 add_term,
  input  logic [63:0]          term_in,
  input  logic [63:0]          x2_in,
  input  logic signed [63:0]   sum_in,
  output logic [63:0]          term_out,
  output logic [63:0]          x2_out,
  output logic signed [63:0]   sum_out
);

  localparam int SIDE_D = SER_CELL_LAT - 1;

  logic [127:0]       pa;
  logic [127:0]       pb;
  logic [63:0]        t;
  logic [63:0]        t_d [MUL_LAT];
  logic [63:0]        x2_d [SIDE_D];
  logic signed [63:0] sum_d [SIDE_D];
  logic [63:0]        q_est;
  logic [63:0]        qd;
  logic [63:0]        q_r;
  logic [63:0]        t_r;
  logic [63:0]        rem;
  logic [63:0]        q;

  // term times x squared
  bmg_mul u_term (
    .clk (clk),
    .en  (en),
    .a   (term_in),
    .b   (x2_in),
    .p   (pa)
  );

  assign t = pa[FQ +: 64];

  // quotient estimate by the reciprocal, low by at most one
  bmg_mul u_recip (
    .clk (clk),
    .en  (en),
    .a   (t),
    .b   (recip),
    .p   (pb)
  );

  assign q_est = pb[127:64];

  // correction of the estimate
  always_comb begin
    rem = t_r - qd;
    q   = q_r + 64'(rem >= 64'(div));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_d[0]   <= t;
      x2_d[0]  <= x2_in;
      sum_d[0] <= sum_in;
      for (int i = 1; i < MUL_LAT; i++) begin
        t_d[i] <= t_d[i-1];
      end
      for (int i = 1; i < SIDE_D; i++) begin
        x2_d[i]  <= x2_d[i-1];
        sum_d[i] <= sum_d[i-1];
      end
      qd       <= q_est * {{(64 - SER_DIV_W){1'b0}}, div};
      q_r      <= q_est;
      t_r      <= t_d[MUL_LAT-1];
      term_out <= q;
      x2_out   <= x2_d[SIDE_D-1];
      sum_out  <= add_term ? (sum_d[SIDE_D-1] + $signed(q)) : (sum_d[SIDE_D-1] - $signed(q));
    end
  end

endmodule
